@@ rtl/core/gpio_pkg.sv @@
// Shared types, register offsets and operation codes of the GPIO port.
package gpio_pkg;

    localparam int PIN_COUNT_DEFAULT = 8;
    localparam int BUS_WIDTH = 8;
    localparam int WORD_WIDTH = 10;
    localparam int MODE_WIDTH = 2;

    // item operation codes
    localparam logic [MODE_WIDTH-1:0] MODE_READ   = 2'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_WRITE  = 2'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_SAMPLE = 2'd2;

    // register word offsets above the masked data window
    localparam logic [WORD_WIDTH-1:0] WORD_DIR   = 10'd256;
    localparam logic [WORD_WIDTH-1:0] WORD_LEVEL = 10'd257;
    localparam logic [WORD_WIDTH-1:0] WORD_BOTH  = 10'd258;
    localparam logic [WORD_WIDTH-1:0] WORD_POL   = 10'd259;
    localparam logic [WORD_WIDTH-1:0] WORD_EN    = 10'd260;
    localparam logic [WORD_WIDTH-1:0] WORD_RAW   = 10'd261;
    localparam logic [WORD_WIDTH-1:0] WORD_MIS   = 10'd262;
    localparam logic [WORD_WIDTH-1:0] WORD_CLR   = 10'd263;

    typedef struct packed {
        logic [MODE_WIDTH-1:0] mode;
        logic [WORD_WIDTH-1:0] word_index;
        logic [BUS_WIDTH-1:0]  write_data;
        logic [BUS_WIDTH-1:0]  pin_levels;
    } in_item_t;

    typedef struct packed {
        logic [BUS_WIDTH-1:0] read_data;
        logic [BUS_WIDTH-1:0] pin_drive;
        logic [BUS_WIDTH-1:0] pin_enable;
        logic                 irq;
    } out_item_t;

endpackage

@@ rtl/core/gpio_detect.sv @@
// Per-pin edge and level event detection for a pin sample.
module gpio_detect #(
    parameter int PIN_COUNT = gpio_pkg::PIN_COUNT_DEFAULT
) (
    input  logic [PIN_COUNT-1:0] pins,
    input  logic [PIN_COUNT-1:0] last_pins,
    input  logic [PIN_COUNT-1:0] level_sense,
    input  logic [PIN_COUNT-1:0] both_edges,
    input  logic [PIN_COUNT-1:0] polarity,
    output logic [PIN_COUNT-1:0] hit
);

    logic [PIN_COUNT-1:0] rise;
    logic [PIN_COUNT-1:0] fall;
    logic [PIN_COUNT-1:0] edge_sel;
    logic [PIN_COUNT-1:0] edge_hit;
    logic [PIN_COUNT-1:0] level_hit;

    assign rise      = pins & ~last_pins;
    assign fall      = last_pins & ~pins;
    assign edge_sel  = (rise & polarity) | (fall & ~polarity);
    assign edge_hit  = (both_edges & (rise | fall)) | (~both_edges & edge_sel);
    // level pins fire while the level matches polarity
    assign level_hit = ~(pins ^ polarity);
    assign hit       = (level_sense & level_hit) | (~level_sense & edge_hit);

endmodule

@@ rtl/core/gpio_regs.sv @@
// GPIO register file: bus decode, state update and result formation.
module gpio_regs #(
    parameter int PIN_COUNT = gpio_pkg::PIN_COUNT_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  gpio_pkg::in_item_t item,
    output gpio_pkg::out_item_t result
);

    logic [PIN_COUNT-1:0] out_data_reg,    out_data_next;
    logic [PIN_COUNT-1:0] direction_reg,   direction_next;
    logic [PIN_COUNT-1:0] level_sense_reg, level_sense_next;
    logic [PIN_COUNT-1:0] both_edges_reg,  both_edges_next;
    logic [PIN_COUNT-1:0] polarity_reg,    polarity_next;
    logic [PIN_COUNT-1:0] irq_enable_reg,  irq_enable_next;
    logic [PIN_COUNT-1:0] raw_status_reg,  raw_status_next;
    logic [PIN_COUNT-1:0] last_pins_reg,   last_pins_next;

    logic [PIN_COUNT-1:0] wdata;
    logic [PIN_COUNT-1:0] pins;
    logic [PIN_COUNT-1:0] mask;
    logic [PIN_COUNT-1:0] pin_view;
    logic [PIN_COUNT-1:0] rdata;
    logic [PIN_COUNT-1:0] hit;
    logic                 in_window;

    assign wdata     = item.write_data[PIN_COUNT-1:0];
    assign pins      = item.pin_levels[PIN_COUNT-1:0];
    assign mask      = item.word_index[PIN_COUNT-1:0];
    assign in_window = (item.word_index[gpio_pkg::WORD_WIDTH-1:8] == 2'b00);
    assign pin_view  = (out_data_reg & direction_reg) | (last_pins_reg & ~direction_reg);

    gpio_detect #(
        .PIN_COUNT(PIN_COUNT)
    ) u_detect (
        .pins        (pins),
        .last_pins   (last_pins_reg),
        .level_sense (level_sense_reg),
        .both_edges  (both_edges_reg),
        .polarity    (polarity_reg),
        .hit         (hit)
    );

    always_comb
    begin
        out_data_next    = out_data_reg;
        direction_next   = direction_reg;
        level_sense_next = level_sense_reg;
        both_edges_next  = both_edges_reg;
        polarity_next    = polarity_reg;
        irq_enable_next  = irq_enable_reg;
        raw_status_next  = raw_status_reg;
        last_pins_next   = last_pins_reg;
        rdata            = '0;

        unique case (item.mode)
            gpio_pkg::MODE_READ:
            begin
                if (in_window)
                begin
                    rdata = pin_view & mask;
                end
                else
                begin
                    unique case (item.word_index)
                        gpio_pkg::WORD_DIR:   rdata = direction_reg;
                        gpio_pkg::WORD_LEVEL: rdata = level_sense_reg;
                        gpio_pkg::WORD_BOTH:  rdata = both_edges_reg;
                        gpio_pkg::WORD_POL:   rdata = polarity_reg;
                        gpio_pkg::WORD_EN:    rdata = irq_enable_reg;
                        gpio_pkg::WORD_RAW:   rdata = raw_status_reg;
                        gpio_pkg::WORD_MIS:   rdata = raw_status_reg & irq_enable_reg;
                        default:              rdata = '0;
                    endcase
                end
            end
            gpio_pkg::MODE_WRITE:
            begin
                if (in_window)
                begin
                    out_data_next = (out_data_reg & ~mask) | (wdata & mask);
                end
                else
                begin
                    unique case (item.word_index)
                        gpio_pkg::WORD_DIR:   direction_next   = wdata;
                        gpio_pkg::WORD_LEVEL: level_sense_next = wdata;
                        gpio_pkg::WORD_BOTH:  both_edges_next  = wdata;
                        gpio_pkg::WORD_POL:   polarity_next    = wdata;
                        gpio_pkg::WORD_EN:    irq_enable_next  = wdata;
                        gpio_pkg::WORD_CLR:   raw_status_next  = raw_status_reg & ~wdata;
                        default:              ;
                    endcase
                end
            end
            gpio_pkg::MODE_SAMPLE:
            begin
                raw_status_next = raw_status_reg | hit;
                last_pins_next  = pins;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_data_reg    <= '0;
            direction_reg   <= '0;
            level_sense_reg <= '0;
            both_edges_reg  <= '0;
            polarity_reg    <= '0;
            irq_enable_reg  <= '0;
            raw_status_reg  <= '0;
            last_pins_reg   <= '0;
        end
        else if (go)
        begin
            out_data_reg    <= out_data_next;
            direction_reg   <= direction_next;
            level_sense_reg <= level_sense_next;
            both_edges_reg  <= both_edges_next;
            polarity_reg    <= polarity_next;
            irq_enable_reg  <= irq_enable_next;
            raw_status_reg  <= raw_status_next;
            last_pins_reg   <= last_pins_next;
        end
    end

    // result shows the state after this item's update
    assign result.read_data  = gpio_pkg::BUS_WIDTH'(rdata);
    assign result.pin_drive  = gpio_pkg::BUS_WIDTH'(out_data_next);
    assign result.pin_enable = gpio_pkg::BUS_WIDTH'(direction_next);
    assign result.irq        = |(raw_status_next & irq_enable_next);

endmodule

@@ rtl/core/gpio_port_with_pin_interrupts.sv @@
// Top level of the GPIO port: input register, register file and result register.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-----------------------------------
//  item     | item_valid / item_stall     | in_item_t  (mode, word, data, pins)
//  result   | result_valid / result_stall | out_item_t (read, drive, enable, irq)
//
// One transfer per cycle is sustained on both sides while result is not stalled.
// An item waits in the input register, is applied to the register file as it
// moves into the result register, and is valid on result from that edge on
// until its result transfer.
// Reset (rst_n low, asynchronous) clears all port registers and both stages.
// A stall on result holds the result register; the input register then fills
// and item_stall rises, so at most two items are in flight.
module gpio_port_with_pin_interrupts #(
    parameter int PIN_COUNT = gpio_pkg::PIN_COUNT_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  gpio_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output gpio_pkg::out_item_t result
);

    logic                in_valid_reg;
    gpio_pkg::in_item_t  in_item_reg;
    logic                out_valid_reg;
    gpio_pkg::out_item_t out_item_reg;
    gpio_pkg::out_item_t out_item_next;
    logic                advance;
    logic                take_in;

    // the held item moves on when the result slot is empty or being drained
    assign advance    = in_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = in_valid_reg && !advance;
    assign take_in    = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take_in || advance)
        begin
            in_valid_reg <= take_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_item_reg <= item;
        end
    end

    // state is committed only when the item is handed to the result register
    gpio_regs #(
        .PIN_COUNT(PIN_COUNT)
    ) u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (advance),
        .item   (in_item_reg),
        .result (out_item_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule
